@@ rtl/core/dssw_pkg.sv @@
// Shared constants and helpers for the decimal seven-segment writer.
// No dependencies; every module of the block imports this package.
package dssw_pkg;

  localparam int NUMBER_W            = 32;
  localparam int BCD_DIGITS          = 10;
  localparam int NUM_POSITIONS       = 8;
  localparam int DIGIT_COUNT_DEFAULT = 8;

  localparam logic [2:0] CH_POSITION = 3'd6;
  localparam logic [2:0] CH_SEGMENT  = 3'd7;
  localparam logic [7:0] SEG_BLANK   = 8'hff;

  // Clamp the configured digit count to between one and what the display can show.
  function automatic int dssw_limit(input int digit_count);
    int lim;
    lim = digit_count;
    if (lim > NUM_POSITIONS) lim = NUM_POSITIONS;
    if (lim < 1) lim = 1;
    return lim;
  endfunction

  // Common-anode, active-low segment pattern of one decimal digit.
  function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
    logic [7:0] pat;
    unique case (digit)
      4'd0:    pat = 8'hc0;
      4'd1:    pat = 8'hf9;
      4'd2:    pat = 8'ha4;
      4'd3:    pat = 8'hb0;
      4'd4:    pat = 8'h99;
      4'd5:    pat = 8'h92;
      4'd6:    pat = 8'h82;
      4'd7:    pat = 8'hf8;
      4'd8:    pat = 8'h80;
      4'd9:    pat = 8'h90;
      default: pat = SEG_BLANK;
    endcase
    return pat;
  endfunction

endpackage

@@ rtl/core/dssw_front.sv @@
// Front end: accepts a number, converts it to BCD by shift-and-add-3,
// and queues a display job. Depends on dssw_pkg.
module dssw_front
  import dssw_pkg::*;
#(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEFAULT,
  localparam int LIMIT = dssw_limit(DIGIT_COUNT),
  localparam int CW = $clog2(LIMIT + 1),
  localparam int JW = LIMIT * 4 + CW + 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [NUMBER_W-1:0] number,
  output logic                full,
  output logic                q_push,
  output logic [JW-1:0]       q_data,
  input  logic                q_full
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_CONV = 2'd1;
  localparam logic [1:0] F_DONE = 2'd2;

  logic [1:0]              state;
  logic [4:0]              step;
  logic [NUMBER_W-1:0]     shreg;
  logic [BCD_DIGITS*4-1:0] bcd;
  logic [BCD_DIGITS*4-1:0] bcd_adj;
  logic [3:0]              ndig;
  logic [CW-1:0]           shown;
  logic                    ovf;
  logic                    done_go;

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  // Count significant digits; zero has none.
  always_comb begin
    ndig = 4'd0;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) ndig = 4'(i + 1);
    end
  end

  assign ovf   = (ndig > 4'(LIMIT));
  assign shown = ovf ? CW'(LIMIT) : CW'(ndig);

  assign done_go = (state == F_DONE) && ((ndig == 4'd0) || !q_full);
  assign q_push  = (state == F_DONE) && (ndig != 4'd0) && !q_full;
  assign q_data  = {ovf, shown, bcd[LIMIT*4-1:0]};
  assign full    = (state != F_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      step  <= 5'd0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (push) begin
            state <= F_CONV;
            step  <= 5'd0;
          end
        end
        F_CONV: begin
          step <= step + 5'd1;
          if (step == 5'd31) state <= F_DONE;
        end
        F_DONE: begin
          if (done_go) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && push) begin
      shreg <= number;
      bcd   <= '0;
    end else if (state == F_CONV) begin
      shreg <= {shreg[NUMBER_W-2:0], 1'b0};
      bcd   <= {bcd_adj[BCD_DIGITS*4-2:0], shreg[NUMBER_W-1]};
    end
  end

  // A job of zero digits must never reach the back end.
  a_no_empty_job: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (shown != '0) && (state == F_DONE))
    else $error("front queued an empty job");

endmodule

@@ rtl/core/dssw_queue.sv @@
// Two-entry job queue between front and back ends.
// Depends on dssw_pkg for the shared digit-count default and limit function.
module dssw_queue
  import dssw_pkg::*;
#(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEFAULT,
  localparam int LIMIT = dssw_limit(DIGIT_COUNT),
  localparam int CW = $clog2(LIMIT + 1),
  localparam int JW = LIMIT * 4 + CW + 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  logic [JW-1:0] wr_data,
  output logic          q_full,
  input  logic          rd,
  output logic [JW-1:0] rd_data,
  output logic          q_empty
);

  logic [JW-1:0] slots [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    count;

  assign q_full  = (count == 2'd2);
  assign q_empty = (count == 2'd0);
  assign rd_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr) slots[wptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) wptr <= ~wptr;
      if (rd) rptr <= ~rptr;
      case ({wr, rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (wr |-> !q_full) and (rd |-> !q_empty))
    else $error("job queue overrun or underrun");

endmodule

@@ rtl/core/dssw_back.sv @@
// Back end: walks a queued job digit by digit and issues three latch
// writes per digit into a one-item output register. Depends on dssw_pkg.
module dssw_back
  import dssw_pkg::*;
#(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEFAULT,
  localparam int LIMIT = dssw_limit(DIGIT_COUNT),
  localparam int CW = $clog2(LIMIT + 1),
  localparam int JW = LIMIT * 4 + CW + 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [JW-1:0] job,
  input  logic          q_empty,
  output logic          q_rd,
  output logic          empty,
  input  logic          pop,
  output logic [2:0]    latch_channel,
  output logic [7:0]    port_byte,
  output logic          last,
  output logic          overflow
);

  localparam logic       B_IDLE  = 1'b0;
  localparam logic       B_RUN   = 1'b1;
  localparam logic [1:0] P_BLANK = 2'd0;
  localparam logic [1:0] P_POS   = 2'd1;
  localparam logic [1:0] P_SEG   = 2'd2;

  logic                 state;
  logic [1:0]           phase;
  logic [LIMIT*4-1:0]   digits;
  logic [CW-1:0]        remaining;
  logic [2:0]           pos;
  logic                 ovf;
  logic                 out_valid;
  logic                 out_free;
  logic                 out_load;
  logic [2:0]           ch_next;
  logic [7:0]           byte_next;
  logic                 last_next;
  logic [7:0]           mask;

  assign out_free = !out_valid || pop;
  assign out_load = (state == B_RUN) && out_free;
  assign q_rd     = (state == B_IDLE) && !q_empty;
  assign empty    = !out_valid;
  assign mask     = 8'b1 << pos;

  always_comb begin
    ch_next   = CH_SEGMENT;
    byte_next = SEG_BLANK;
    last_next = 1'b0;
    unique case (phase)
      P_BLANK: begin
        ch_next   = CH_SEGMENT;
        byte_next = SEG_BLANK;
      end
      P_POS: begin
        ch_next   = CH_POSITION;
        byte_next = mask;
      end
      P_SEG: begin
        ch_next   = CH_SEGMENT;
        byte_next = seg_pattern(digits[3:0]);
        last_next = (remaining == CW'(1));
      end
      default: begin
        ch_next   = CH_SEGMENT;
        byte_next = SEG_BLANK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      phase     <= P_BLANK;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (q_rd) begin
            state <= B_RUN;
            phase <= P_BLANK;
          end
        end
        B_RUN: begin
          if (out_load) begin
            if (phase == P_SEG) begin
              phase <= P_BLANK;
              if (remaining == CW'(1)) state <= B_IDLE;
            end else begin
              phase <= phase + 2'd1;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // Job payload: digits shift out low first, position walks right to left.
  always_ff @(posedge clk) begin
    if (q_rd) begin
      {ovf, remaining, digits} <= job;
      pos <= 3'(NUM_POSITIONS - 1);
    end else if (out_load && phase == P_SEG) begin
      digits    <= digits >> 4;
      remaining <= remaining - CW'(1);
      pos       <= pos - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      latch_channel <= ch_next;
      port_byte     <= byte_next;
      last          <= last_next;
      overflow      <= ovf;
    end
  end

  a_job_nonzero: assert property (@(posedge clk) disable iff (rst)
    q_rd |-> (job[JW-2 -: CW] != '0))
    else $error("back end took a job without digits");

  a_pos_onehot: assert property (@(posedge clk) disable iff (rst)
    out_load && phase == P_POS |=> $onehot(port_byte) && latch_channel == CH_POSITION)
    else $error("position write is not one-hot");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_load && last_next |=> state == B_IDLE)
    else $error("last write did not end the run");

endmodule

@@ rtl/core/decimal_seven_segment_writer_top.sv @@
// Top level of the decimal seven-segment writer: front end, job queue
// and back end. Depends on dssw_pkg, dssw_front, dssw_queue, dssw_back.
//
// Usage:
//   Input channel: drive number and raise push; the number is taken at a
//   clock edge with push high and full low. Each number is converted to
//   BCD one bit a cycle, then queued as a job; full stays high from each
//   accepted number until its job is queued, or dropped if it is zero.
//   Result channel: while empty is low, latch_channel/port_byte/last/
//   overflow hold the oldest write; pulse pop to take it. Each shown digit
//   gives three writes: blank segments, select position, show pattern.
//   Digits go least significant first, from the rightmost position leftward.
//   At most min(max(DIGIT_COUNT, 1), 8) digits are shown; overflow marks
//   every write of a number with more digits. A zero input produces no writes.
//   A number's writes reach the result ports after its conversion, the job
//   queue and the back end's output register; while pop is held, the back
//   end issues one write per cycle within a run.
//   A new number waits until the serial BCD loop has finished the last one.
//   Stalls: holding pop low freezes the back end on its current run; the
//   two-entry job queue takes two more jobs and the front end converts and
//   holds one more, after which full stays up.
//   Reset (rst, synchronous) empties the queue and output register.
module decimal_seven_segment_writer_top
  import dssw_pkg::*;
#(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [NUMBER_W-1:0] number,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output logic [2:0]          latch_channel,
  output logic [7:0]          port_byte,
  output logic                last,
  output logic                overflow
);

  localparam int LIMIT = dssw_limit(DIGIT_COUNT);
  localparam int CW    = $clog2(LIMIT + 1);
  localparam int JW    = LIMIT * 4 + CW + 1;

  logic          q_wr;
  logic [JW-1:0] q_wdata;
  logic          q_full;
  logic          q_rd;
  logic [JW-1:0] q_rdata;
  logic          q_empty;

  // Accept and convert numbers; hand finished jobs to the queue.
  dssw_front #(.DIGIT_COUNT(DIGIT_COUNT)) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .number (number),
    .full   (full),
    .q_push (q_wr),
    .q_data (q_wdata),
    .q_full (q_full)
  );

  // Decouple conversion from display writes.
  dssw_queue #(.DIGIT_COUNT(DIGIT_COUNT)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data (q_wdata),
    .q_full  (q_full),
    .rd      (q_rd),
    .rd_data (q_rdata),
    .q_empty (q_empty)
  );

  // Issue latch writes for each queued job.
  dssw_back #(.DIGIT_COUNT(DIGIT_COUNT)) u_back (
    .clk           (clk),
    .rst           (rst),
    .job           (q_rdata),
    .q_empty       (q_empty),
    .q_rd          (q_rd),
    .empty         (empty),
    .pop           (pop),
    .latch_channel (latch_channel),
    .port_byte     (port_byte),
    .last          (last),
    .overflow      (overflow)
  );

endmodule

@@ verif/dssw_tb_pkg.sv @@
// Scoreboard for the decimal seven-segment writer bench: expected latch writes per number.
// Depends on dssw_pkg for the latch channel codes, the blank byte and the position count.
package dssw_tb_pkg;
  import dssw_pkg::*;

  typedef struct packed {
    logic [2:0] channel;
    logic [7:0] data;
    logic       last;
    logic       overflow;
  } display_write_t;

  class display_write_scoreboard;
    int unsigned    shown_limit;
    int unsigned    mismatch_count;
    display_write_t expected_writes[$];
    logic [7:0]     glyph[10];

    function new(int digit_count);
      glyph = '{8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8, 8'h80, 8'h90};
      if (digit_count > NUM_POSITIONS) begin
        shown_limit = NUM_POSITIONS;
      end else if (digit_count < 1) begin
        shown_limit = 1;
      end else begin
        shown_limit = digit_count;
      end
      mismatch_count = 0;
    endfunction

    function display_write_t make_write(logic [2:0] channel, logic [7:0] data);
      display_write_t w;
      w.channel  = channel;
      w.data     = data;
      w.last     = 1'b0;
      w.overflow = 1'b0;
      return w;
    endfunction

    // Split an accepted number into digits and queue its three writes per digit.
    function void note_number(logic [31:0] value);
      logic [31:0]    rest;
      int unsigned    shown;
      logic           spill;
      display_write_t run[$];
      rest  = value;
      shown = 0;
      while (rest != 0 && shown < shown_limit) begin
        run.push_back(make_write(CH_SEGMENT, SEG_BLANK));
        run.push_back(make_write(CH_POSITION, 8'h80 >> shown));
        run.push_back(make_write(CH_SEGMENT, glyph[rest % 10]));
        rest  = rest / 10;
        shown++;
      end
      spill = (rest != 0);
      foreach (run[i]) begin
        run[i].overflow = spill;
        run[i].last     = (i == run.size() - 1);
        expected_writes.push_back(run[i]);
      end
    endfunction

    function void report_field(string name, logic [7:0] want, logic [7:0] seen);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
      mismatch_count++;
    endfunction

    function void check_write(display_write_t got);
      display_write_t want;
      if (expected_writes.size() == 0) begin
        $display("%0t: unexpected write, expected none, actual ch=%0d byte=%h last=%b ovf=%b",
                 $time, got.channel, got.data, got.last, got.overflow);
        mismatch_count++;
        return;
      end
      want = expected_writes.pop_front();
      if (got.channel !== want.channel)
        report_field("latch_channel", 8'(want.channel), 8'(got.channel));
      if (got.data !== want.data) report_field("port_byte", want.data, got.data);
      if (got.last !== want.last) report_field("last", 8'(want.last), 8'(got.last));
      if (got.overflow !== want.overflow)
        report_field("overflow", 8'(want.overflow), 8'(got.overflow));
    endfunction
  endclass

endpackage

@@ verif/tb_decimal_seven_segment_writer_top.sv @@
// Self-checking bench for decimal_seven_segment_writer_top: directed and random numbers.
// Depends on dssw_pkg, dssw_tb_pkg and the block's RTL.
module tb_decimal_seven_segment_writer_top;
  import dssw_pkg::*;
  import dssw_tb_pkg::*;

  localparam int DIGITS         = DIGIT_COUNT_DEFAULT;
  localparam int RANDOM_NUMBERS = 300;
  localparam int CORNER_COUNT   = 18;
  localparam int QUIET_FROM     = 120;   // window with no idling on either side
  localparam int QUIET_TO       = 160;
  localparam int TAIL_START     = 280;   // no idling from here to the end
  localparam int HOLD_AT        = 40;    // start the long receiver hold-off here
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 120;   // room for a stray run after the last expected write
  localparam int STUCK_LIMIT    = 3000;

  logic                clk;
  logic                rst;
  logic                push;
  logic [NUMBER_W-1:0] number;
  logic                full;
  logic                pop;
  logic                empty;
  logic [2:0]          latch_channel;
  logic [7:0]          port_byte;
  logic                last;
  logic                overflow;

  display_write_scoreboard write_board;
  int unsigned             numbers_accepted;
  int unsigned             stuck_cycles;

  // Field extremes, digit boundaries and every glyph.
  logic [31:0] corner_numbers[CORNER_COUNT] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd42, 32'd1234567890, 32'd98765432, 32'd99999999,
    32'd100000000, 32'd10000000, 32'hffffffff, 32'h80000000, 32'h55555555,
    32'haaaaaaaa, 32'd12345678, 32'd7, 32'd0, 32'd100
  };

  decimal_seven_segment_writer_top #(.DIGIT_COUNT(DIGITS)) dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .number        (number),
    .full          (full),
    .pop           (pop),
    .empty         (empty),
    .latch_channel (latch_channel),
    .port_byte     (port_byte),
    .last          (last),
    .overflow      (overflow)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Allow idle bursts outside the quiet window and the tail.
  function automatic bit idle_allowed(int unsigned count);
    return (count < QUIET_FROM) || (count >= QUIET_TO && count < TAIL_START);
  endfunction

  // Bias toward short numbers and the eight-digit boundary; keep some full-width values.
  function automatic logic [31:0] random_number();
    int unsigned       pick;
    int unsigned       digits;
    longint unsigned   span;
    logic [31:0]       value;
    pick = $urandom_range(0, 15);
    if (pick == 0) begin
      value = $urandom_range(0, 9);
    end else if (pick <= 2) begin
      value = 32'd99999990 + $urandom_range(0, 20);
    end else if (pick <= 9) begin
      digits = $urandom_range(1, 9);
      span   = 1;
      repeat (digits) span = span * 10;
      value  = 32'($urandom % span);
    end else begin
      value = $urandom;
    end
    return value;
  endfunction

  // Offer one number from a falling edge; hold it until taken, then note it.
  task automatic send_number(input logic [31:0] value);
    number <= value;
    push   <= 1'b1;
    do @(posedge clk); while (full);
    write_board.note_number(value);
    numbers_accepted++;
    @(negedge clk);
  endtask

  // Drop push for a random burst now and then.
  task automatic sender_pause();
    int unsigned gap;
    if (idle_allowed(numbers_accepted) && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 6);
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Sender: reset, directed corners, random numbers, then drain and report.
  initial begin
    rst              = 1'b1;
    push             = 1'b0;
    number           = '0;
    numbers_accepted = 0;
    write_board      = new(DIGITS);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (corner_numbers[i]) begin
      send_number(corner_numbers[i]);
      sender_pause();
    end
    for (int i = 0; i < RANDOM_NUMBERS; i++) begin
      send_number(random_number());
      sender_pause();
    end
    push <= 1'b0;
    // Wait for every queued write, then give a zero or stray run time to show up.
    while (write_board.expected_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (write_board.mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Receiver: one long hold-off to fill the block, random stall bursts otherwise.
  initial begin : receiver
    bit          held;
    int unsigned stall;
    held = 1'b0;
    pop  = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && numbers_accepted >= HOLD_AT) begin
        pop  <= 1'b0;
        held = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (idle_allowed(numbers_accepted) && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 6);
        pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end else begin
        pop <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Check each write as it is taken.
  always @(posedge clk) begin
    display_write_t seen;
    if (!rst && pop && !empty) begin
      seen.channel  = latch_channel;
      seen.data     = port_byte;
      seen.last     = last;
      seen.overflow = overflow;
      write_board.check_write(seen);
    end
  end

  // Watchdog: count cycles in which no item moves on either side.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STUCK_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

endmodule
